/* design/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler package
// Shared types and constants for the scheduler controller, datapath and top.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int TICK_W    = 24;
   localparam int ID_W      = 16;
   localparam int CPU_W     = 16;
   localparam int WAIT_W    = 31;
   localparam int ACT_W     = 2;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;

   // One full tick of CPU time in hundredths.
   localparam logic [CPU_W-1:0] ONE_TICK = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPATCH_COST = 2'd1;

   localparam logic [ACT_W-1:0] ACT_IDLE     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DISPATCH = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RUN      = 2'd2;

   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   typedef enum logic [1:0] {
      PH_FREE     = 2'd0,
      PH_DISPATCH = 2'd1,
      PH_RUN      = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_POP  = 2'd1,
      ST_EXEC = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic             mode;
      logic [ID_W-1:0]  task_id;
      logic [CPU_W-1:0] cpu_need;
   } req_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick_time;
      logic [ACT_W-1:0]  activity;
      logic [ID_W-1:0]   current_id;
      logic [CPU_W-1:0]  used_before;
      logic              zero_cost_dispatch;
      logic              finished;
      logic [TICK_W-1:0] turnaround;
      logic [WAIT_W-1:0] waiting;
      logic              queue_overflow;
   } rsp_type;

   // One ready-queue entry: id, arrival tick, request, CPU used so far.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] arrival;
      logic [CPU_W-1:0]  request;
      logic [CPU_W-1:0]  used;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic arrive;   // take an arrival transaction
      logic tick;     // take a tick transaction, advance the tick counter
      logic pop;      // load the queue head into the running task
      logic exec;     // process the tick and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_pop; // CPU free and the ready queue holds a task
   } stat_type;

endpackage

/* design/rrts_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rrts_ctrl.sv */
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences arrival and tick transactions and owns the result valid flag.
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_mode,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  rrts_pkg::stat_type status,
   output rrts_pkg::cmd_type  cmd
);

   rrts_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_take;
   logic out_busy;

   assign req_take = req_valid && (state_ff == rrts_pkg::ST_IDLE);
   // The result register is full and its transaction is not completing now.
   assign out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_take && (req_mode == rrts_pkg::MODE_TICK)) begin
               state_in = status.need_pop ? rrts_pkg::ST_POP : rrts_pkg::ST_EXEC;
            end
         end
         rrts_pkg::ST_POP: begin
            state_in = rrts_pkg::ST_EXEC;
         end
         rrts_pkg::ST_EXEC: begin
            if (!out_busy) begin
               state_in = rrts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrts_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         rrts_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.arrive = req_take && (req_mode == rrts_pkg::MODE_ARRIVAL);
            cmd.tick   = req_take && (req_mode == rrts_pkg::MODE_TICK);
         end
         rrts_pkg::ST_POP: begin
            cmd.pop = 1'b1;
         end
         rrts_pkg::ST_EXEC: begin
            cmd.exec = !out_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/rrts_dp.sv */
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready queue, running task, tick counter, configuration and result register.
// ----------------------------------------------------------------------------
module rrts_dp #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rrts_pkg::cmd_type                      cmd,
   output rrts_pkg::stat_type                     status,
   input  rrts_pkg::req_type                      req_data,
   output rrts_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write,
   input  logic [rrts_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rrts_pkg::CFG_W-1:0]             csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W:0]   CNT_LIMIT = (CNT_W + 1)'(QUEUE_DEPTH);

   logic [rrts_pkg::CFG_W-1:0]  quantum_ff, quantum_in;
   logic [rrts_pkg::CFG_W-1:0]  cost_ff, cost_in;
   logic [rrts_pkg::TICK_W-1:0] tick_ff, tick_in;
   rrts_pkg::phase_type         phase_ff, phase_in;
   logic [rrts_pkg::CFG_W-1:0]  pc_ff, pc_in;
   logic [rrts_pkg::ID_W-1:0]   run_id_ff, run_id_in;
   logic [rrts_pkg::TICK_W-1:0] run_arr_ff, run_arr_in;
   logic [rrts_pkg::CPU_W-1:0]  run_req_ff, run_req_in;
   logic [rrts_pkg::CPU_W-1:0]  run_used_ff, run_used_in;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [PTR_W-1:0]            tail_ff, tail_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic                        zero_ff, zero_in;
   rrts_pkg::rsp_type           rsp_ff, rsp_in;

   rrts_pkg::entry_type         wr_entry, rd_entry;
   logic                        wr_en;
   logic [rrts_pkg::ENTRY_W-1:0] rd_bits;

   logic                        room;
   logic                        arrive_ok;
   logic                        requeue;
   logic [rrts_pkg::CFG_W-1:0]  q_eff;
   logic [rrts_pkg::CPU_W-1:0]  left;
   logic [rrts_pkg::CPU_W-1:0]  burst;
   logic [rrts_pkg::CPU_W-1:0]  used_new;
   logic [rrts_pkg::CFG_W-1:0]  pc_inc;
   logic [rrts_pkg::CFG_W-1:0]  pc_dec;
   logic                        done;
   logic [rrts_pkg::TICK_W-1:0] ta;
   logic [rrts_pkg::WAIT_W-1:0] ta_ext;
   logic [rrts_pkg::WAIT_W-1:0] ta_x100;

   // A slot stays reserved for a task in service so it can always return.
   assign room = ({1'b0, count_ff} + {{CNT_W{1'b0}}, (phase_ff != rrts_pkg::PH_FREE)})
                 < CNT_LIMIT;
   assign arrive_ok = cmd.arrive && room;
   assign status.need_pop = (phase_ff == rrts_pkg::PH_FREE) && (count_ff != '0);

   assign q_eff    = (quantum_ff == '0) ? rrts_pkg::CFG_W'(1) : quantum_ff;
   assign left     = (run_req_ff > run_used_ff) ? (run_req_ff - run_used_ff) : '0;
   assign burst    = (left < rrts_pkg::ONE_TICK) ? left : rrts_pkg::ONE_TICK;
   assign used_new = run_used_ff + burst;
   assign pc_inc   = pc_ff + rrts_pkg::CFG_W'(1);
   assign pc_dec   = (pc_ff != '0) ? (pc_ff - rrts_pkg::CFG_W'(1)) : '0;
   assign done     = (used_new >= run_req_ff);
   assign ta       = tick_ff + rrts_pkg::TICK_W'(1) - run_arr_ff;
   assign ta_ext   = rrts_pkg::WAIT_W'(ta);
   // Times 100 as 64 + 32 + 4.
   assign ta_x100  = (ta_ext << 6) + (ta_ext << 5) + (ta_ext << 2);
   assign requeue  = cmd.exec && (phase_ff == rrts_pkg::PH_RUN) && !done && (pc_inc >= q_eff);

   assign rd_entry = rrts_pkg::entry_type'(rd_bits);

   always_comb begin
      wr_en    = arrive_ok || requeue;
      wr_entry = '0;
      if (requeue) begin
         wr_entry.id      = run_id_ff;
         wr_entry.arrival = run_arr_ff;
         wr_entry.request = run_req_ff;
         wr_entry.used    = used_new;
      end else begin
         wr_entry.id      = req_data.task_id;
         wr_entry.arrival = tick_ff + rrts_pkg::TICK_W'(1);
         wr_entry.request = req_data.cpu_need;
         wr_entry.used    = '0;
      end
   end

   rrts_ram #(
      .WIDTH (rrts_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.tick),
      .rd_addr (head_ff),
      .rd_data (rd_bits)
   );

   always_comb begin
      quantum_in  = quantum_ff;
      cost_in     = cost_ff;
      tick_in     = tick_ff;
      phase_in    = phase_ff;
      pc_in       = pc_ff;
      run_id_in   = run_id_ff;
      run_arr_in  = run_arr_ff;
      run_req_in  = run_req_ff;
      run_used_in = run_used_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      zero_in     = zero_ff;
      rsp_in      = rsp_ff;

      if (csr_write) begin
         if (csr_index == rrts_pkg::CSR_QUANTUM) begin
            quantum_in = csr_wdata;
         end else if (csr_index == rrts_pkg::CSR_DISPATCH_COST) begin
            cost_in = csr_wdata;
         end
      end

      if (cmd.arrive && !room) begin
         ovf_in = 1'b1;
      end

      if (wr_en) begin
         tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.tick) begin
         tick_in = tick_ff + rrts_pkg::TICK_W'(1);
         zero_in = 1'b0;
      end

      if (cmd.pop) begin
         run_id_in   = rd_entry.id;
         run_arr_in  = rd_entry.arrival;
         run_req_in  = rd_entry.request;
         run_used_in = rd_entry.used;
         head_in     = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
         count_in    = count_ff - CNT_W'(1);
         if (cost_ff == '0) begin
            zero_in  = 1'b1;
            phase_in = rrts_pkg::PH_RUN;
            pc_in    = '0;
         end else begin
            phase_in = rrts_pkg::PH_DISPATCH;
            pc_in    = cost_ff;
         end
      end

      if (cmd.exec) begin
         rsp_in                    = '0;
         rsp_in.tick_time          = tick_ff;
         rsp_in.zero_cost_dispatch = zero_ff;
         rsp_in.queue_overflow     = ovf_ff;
         case (phase_ff)
            rrts_pkg::PH_DISPATCH: begin
               rsp_in.activity    = rrts_pkg::ACT_DISPATCH;
               rsp_in.current_id  = run_id_ff;
               rsp_in.used_before = run_used_ff;
               pc_in              = pc_dec;
               if (pc_dec == '0) begin
                  phase_in = rrts_pkg::PH_RUN;
               end
            end
            rrts_pkg::PH_RUN: begin
               rsp_in.activity    = rrts_pkg::ACT_RUN;
               rsp_in.current_id  = run_id_ff;
               rsp_in.used_before = run_used_ff;
               run_used_in        = used_new;
               pc_in              = pc_inc;
               if (done) begin
                  rsp_in.finished   = 1'b1;
                  rsp_in.turnaround = ta;
                  rsp_in.waiting    = ta_x100 - rrts_pkg::WAIT_W'(used_new);
                  phase_in          = rrts_pkg::PH_FREE;
                  pc_in             = '0;
               end else if (pc_inc >= q_eff) begin
                  phase_in = rrts_pkg::PH_FREE;
                  pc_in    = '0;
               end
            end
            default: begin
               rsp_in.activity = rrts_pkg::ACT_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff  <= rrts_pkg::CFG_W'(1);
         cost_ff     <= '0;
         tick_ff     <= '1;
         phase_ff    <= rrts_pkg::PH_FREE;
         pc_ff       <= '0;
         run_id_ff   <= '0;
         run_arr_ff  <= '0;
         run_req_ff  <= '0;
         run_used_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         zero_ff     <= 1'b0;
      end else begin
         quantum_ff  <= quantum_in;
         cost_ff     <= cost_in;
         tick_ff     <= tick_in;
         phase_ff    <= phase_in;
         pc_ff       <= pc_in;
         run_id_ff   <= run_id_in;
         run_arr_ff  <= run_arr_in;
         run_req_ff  <= run_req_in;
         run_used_ff <= run_used_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         zero_ff     <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/round_robin_time_slice_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler, top level
// Ties the scheduler controller and datapath to the external channels.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_data) carries arrivals
// (mode 0), which append a task stamped with the upcoming tick to the ready
// queue and yield no result, and ticks (mode 1), which advance time by one
// and yield one transaction on the response channel (rsp_valid, rsp_stall,
// rsp_data). The csr port writes quantum (index 0) and dispatch cost (index
// 1); it is always ready; the user must write it only while no transaction
// is in work, as the block does not enforce this. Timing: one transaction is
// in work at a time. A tick passes the pop state when the CPU is free and the
// queue head must come out of the queue memory's registered read port, then
// the exec state; its result is offered from the next cycle on, in which the
// next request is taken. The result register lets requests be taken while a
// result waits; a tick that is ready to finish while the receiver still
// stalls waits, and stalls requests, until that result is taken.
// Reset frees the CPU, empties the queue without clearing its memory and sets
// the tick counter to all ones so that the first tick is number zero.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_top #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rrts_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rrts_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rrts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrts_pkg::CFG_W-1:0]       csr_wdata
);

   rrts_pkg::cmd_type  cmd;
   rrts_pkg::stat_type status;

   // Configuration writes complete in the cycle they are presented.
   assign csr_ready = 1'b1;

   // The controller decides when each transaction is taken and when a
   // result is loaded; it never looks at the payload except the mode bit.
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds all scheduler state, the ready queue memory and
   // the result register.
   rrts_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

/* design/rrts_chk.sv */
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the top-level ports for rule breaks in the scheduler's results.
// ----------------------------------------------------------------------------
module rrts_chk (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rrts_pkg::rsp_type rsp_data
);

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result stays offered and unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Completion and zero-cost dispatch only happen on a running tick.
   a_fin_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.finished || rsp_data.zero_cost_dispatch)
      |-> rsp_data.activity == rrts_pkg::ACT_RUN)
      else $error("finish or zero-cost flag without a running task");

   // An idle tick reports no task.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.activity == rrts_pkg::ACT_IDLE)
      |-> (rsp_data.current_id == '0) && (rsp_data.used_before == '0)
          && !rsp_data.finished)
      else $error("idle tick reports a task");

endmodule

bind round_robin_time_slice_scheduler_top rrts_chk u_rrts_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
